// ===== rtl/cdq_pkg.sv =====
// Shared constants and codes for the circular deque.
// Depends on nothing; circular_deque and the testbench import it.
package cdq_pkg;

    // Storage size and stored word width
    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the item and result
    localparam int KIND_W     = 3;
    localparam int DATA_IN_W  = 32;
    localparam int POS_W      = 10;
    localparam int DATA_OUT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;

    // Derived widths
    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int SUM_W = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

    // Packed stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

// ===== rtl/cdq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module cdq_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/circular_deque.sv =====
// Circular deque: a fixed-capacity double-ended queue of CAPACITY words held in one RAM,
// with head and tail pointers and an entry count in registers. Each item asks for push back,
// push front, pop back, pop front or read at a position from the front, and yields exactly
// one result with the data word, a status and the count after the operation. A push when
// full is refused with status full, a pop when empty with status empty, a read at or beyond
// the count with status out of range; in those cases and on pushes the data word is zero, and
// unknown operation codes leave everything as it was with status ok. For each item, the
// accept cycle updates pointers and issues the RAM access, and the cycle after it collects
// the registered RAM read into the output register. No new item is taken until the
// result is registered, so a following item always sees the RAM after the previous write.
// Depends on cdq_pkg and cdq_ram.
module circular_deque (
    input  logic                               aclk,
    input  logic                               aresetn,
    // item channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cdq_pkg::S_TDATA_W-1:0]      s_tdata,   // [31:0] data_in, [41:32] position
    input  logic [cdq_pkg::KIND_W-1:0]         s_tuser,   // [2:0] kind
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cdq_pkg::M_TDATA_W-1:0]      m_tdata,   // [31:0] data_out, [42:32] count
    output logic [cdq_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);
    import cdq_pkg::*;

    // Unpacked item fields
    logic [KIND_W-1:0]    kind;
    logic [DATA_IN_W-1:0] data_in;
    logic [POS_W-1:0]     position;

    // Deque control state
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;

    // Pending result between accept and output register
    logic                pend_reg;
    logic                pend_rd_reg;
    logic [STATUS_W-1:0] pend_status_reg;
    logic                rd_flag;
    logic [STATUS_W-1:0] status_next;

    // Output register
    logic                  out_valid_reg;
    logic [DATA_OUT_W-1:0] out_data_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    // RAM port signals
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic             accept;
    logic             full;
    logic             empty;
    logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic [SUM_W-1:0] pos_sum;
    logic [PTR_W-1:0] pos_addr;
    logic             pos_bad;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail_expect;

    assign kind     = s_tuser;
    assign data_in  = s_tdata[DATA_IN_W-1:0];
    assign position = s_tdata[DATA_IN_W +: POS_W];

    // Take an item only when nothing is in flight and the output slot is empty or frees up this cycle
    assign s_tready = !pend_reg && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign full  = (cnt_reg == CNT_W'(CAPACITY));
    assign empty = (cnt_reg == '0);

    // Wrapping pointer steps
    assign head_inc = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + PTR_W'(1);
    assign head_dec = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - PTR_W'(1);
    assign tail_inc = (tail_reg == PTR_W'(CAPACITY - 1)) ? '0 : tail_reg + PTR_W'(1);
    assign tail_dec = (tail_reg == '0) ? PTR_W'(CAPACITY - 1) : tail_reg - PTR_W'(1);

    // Read address: head plus position, folded once (position < count <= CAPACITY when valid)
    assign pos_sum  = SUM_W'(head_reg) + SUM_W'(position);
    assign pos_addr = (pos_sum >= SUM_W'(CAPACITY)) ? PTR_W'(pos_sum - SUM_W'(CAPACITY))
                                                    : PTR_W'(pos_sum);
    assign pos_bad  = (CMP_W'(position) >= CMP_W'(cnt_reg));

    // Operation decode
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        status_next = ST_OK;
        rd_flag     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        rd_addr     = head_reg;
        if (accept) begin
            unique case (kind)
                KIND_PUSH_BACK: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        wr_en     = 1'b1;
                        wr_addr   = tail_reg;
                        tail_next = tail_inc;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                end
                KIND_PUSH_FRONT: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        wr_en     = 1'b1;
                        wr_addr   = head_dec;
                        head_next = head_dec;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                end
                KIND_POP_BACK: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        rd_flag   = 1'b1;
                        rd_addr   = tail_dec;
                        tail_next = tail_dec;
                        cnt_next  = cnt_reg - CNT_W'(1);
                    end
                end
                KIND_POP_FRONT: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        rd_flag   = 1'b1;
                        rd_addr   = head_reg;
                        head_next = head_inc;
                        cnt_next  = cnt_reg - CNT_W'(1);
                    end
                end
                KIND_READ: begin
                    if (pos_bad) begin
                        status_next = ST_RANGE;
                    end else begin
                        rd_flag = 1'b1;
                        rd_addr = pos_addr;
                    end
                end
                default: begin
                    // unknown code: change nothing, report ok with zero data
                end
            endcase
        end
    end

    assign rd_en = rd_flag;

    cdq_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (DATA_WIDTH'(data_in)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pointers, count and the pending stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg        <= '0;
            tail_reg        <= '0;
            cnt_reg         <= '0;
            pend_reg        <= 1'b0;
            pend_rd_reg     <= 1'b0;
            pend_status_reg <= ST_OK;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            pend_reg <= accept;
            if (accept) begin
                pend_rd_reg     <= rd_flag;
                pend_status_reg <= status_next;
            end
        end
    end

    // Output register: load from the pending stage, drop once the item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pend_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            out_data_reg   <= pend_rd_reg ? DATA_OUT_W'(rd_data) : '0;
            out_status_reg <= pend_status_reg;
            out_count_reg  <= COUNT_W'(cnt_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_data_reg});

    // Ring consistency: head plus count lands on tail
    assign tail_sum    = SUM_W'(head_reg) + SUM_W'(cnt_reg);
    assign tail_expect = (tail_sum >= SUM_W'(CAPACITY)) ? PTR_W'(tail_sum - SUM_W'(CAPACITY))
                                                        : PTR_W'(tail_sum);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_ring_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg == tail_expect)
        else $error("tail pointer does not match head plus count");

    a_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !s_tready)
        else $error("item accepted while a result is in flight");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |=> out_valid_reg)
        else $error("pending result not registered");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_data_reg == '0))
        else $error("non-zero data on an error result");

endmodule

// ===== verif/tb_circular_deque.sv =====
// Self-checking testbench for circular_deque: queue operations in, one reply out per item.
// Checks every reply against an in-bench prediction of the ring store and its pointers.
// Depends on cdq_pkg and the circular_deque RTL.
module tb_circular_deque;
    import cdq_pkg::*;

    // Kind codes the block does not implement; it must answer them with status ok and no change
    localparam logic [KIND_W-1:0] KIND_FIRST_SPARE = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LAST_SPARE  = 3'd7;

    // Hold-off windows of the receiver, counted in cycles after reset
    localparam int HOLD_A_START = 2000;
    localparam int HOLD_A_END   = 2400;
    localparam int HOLD_B_START = 6000;
    localparam int HOLD_B_END   = 6300;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [DATA_IN_W-1:0] word;
        logic [POS_W-1:0]     pos;
    } deque_op_t;

    typedef struct packed {
        logic [DATA_OUT_W-1:0] data;
        logic [STATUS_W-1:0]   status;
        logic [COUNT_W-1:0]    count;
    } deque_reply_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // Shadow of the block's state
    logic [DATA_WIDTH-1:0] ring_copy [0:CAPACITY-1];
    logic [PTR_W-1:0]      head_idx   = '0;
    logic [PTR_W-1:0]      tail_idx   = '0;
    logic [COUNT_W-1:0]    fill_level = '0;

    deque_op_t    op_queue[$];       // items still to be offered
    deque_reply_t deque_replies[$];  // replies owed by the block, oldest first
    int           gen_fill = 0;      // occupancy as the stimulus generator sees it
    int           mismatch_count = 0;
    logic         in_fire = 1'b0;    // item taken at the last rising edge
    int           gap_left = 0;
    int           burst_left = 0;
    int           rx_cycle = 0;
    rx_mode_t     rx_mode = RX_OPEN;

    circular_deque dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one operation to the shadow state and work out the reply it earns
    task automatic run_deque_op(input logic [KIND_W-1:0] kind, input logic [DATA_IN_W-1:0] word,
                                input logic [POS_W-1:0] pos, output deque_reply_t res);
        logic [PTR_W-1:0] slot;
        res.data   = '0;
        res.status = ST_OK;
        case (kind)
            KIND_PUSH_BACK: begin
                if (fill_level == COUNT_W'(CAPACITY)) begin
                    res.status = ST_FULL;
                end else begin
                    ring_copy[tail_idx] = word[DATA_WIDTH-1:0];
                    tail_idx   = tail_idx + PTR_W'(1);
                    fill_level = fill_level + COUNT_W'(1);
                end
            end
            KIND_PUSH_FRONT: begin
                if (fill_level == COUNT_W'(CAPACITY)) begin
                    res.status = ST_FULL;
                end else begin
                    head_idx   = head_idx - PTR_W'(1);
                    ring_copy[head_idx] = word[DATA_WIDTH-1:0];
                    fill_level = fill_level + COUNT_W'(1);
                end
            end
            KIND_POP_BACK: begin
                if (fill_level == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    tail_idx   = tail_idx - PTR_W'(1);
                    res.data   = ring_copy[tail_idx];
                    fill_level = fill_level - COUNT_W'(1);
                end
            end
            KIND_POP_FRONT: begin
                if (fill_level == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data   = ring_copy[head_idx];
                    head_idx   = head_idx + PTR_W'(1);
                    fill_level = fill_level - COUNT_W'(1);
                end
            end
            KIND_READ: begin
                if (COUNT_W'(pos) >= fill_level) begin
                    res.status = ST_RANGE;
                end else begin
                    slot     = head_idx + pos;
                    res.data = ring_copy[slot];
                end
            end
            default: ;
        endcase
        res.count = fill_level;
    endtask

    // Append one item to the backlog and track how full the deque will be
    task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [DATA_IN_W-1:0] word,
                            input logic [POS_W-1:0] pos);
        deque_op_t op;
        op.kind = kind;
        op.word = word;
        op.pos  = pos;
        op_queue.push_back(op);
        if ((kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT) && gen_fill < CAPACITY)
            gen_fill++;
        else if ((kind == KIND_POP_BACK || kind == KIND_POP_FRONT) && gen_fill > 0)
            gen_fill--;
    endtask

    // Random item with the given push and pop shares in percent; reads and spare kinds fill
    // the remainder. Reads mostly hit a stored entry, the rest land anywhere.
    task automatic queue_random_op(input int push_pct, input int pop_pct);
        int                roll;
        logic [POS_W-1:0]  pos;
        roll = $urandom_range(0, 99);
        pos  = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        if (roll < push_pct) begin
            queue_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, $urandom, pos);
        end else if (roll < push_pct + pop_pct) begin
            queue_op($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK, $urandom, pos);
        end else if (roll < 98) begin
            if (gen_fill > 0 && $urandom_range(0, 3) != 0)
                pos = POS_W'($urandom_range(0, gen_fill - 1));
            queue_op(KIND_READ, $urandom, pos);
        end else begin
            queue_op(KIND_W'($urandom_range(KIND_FIRST_SPARE, KIND_LAST_SPARE)), $urandom, pos);
        end
    endtask

    // Driver: present items at the falling edge, in bursts with random gaps between them
    always @(negedge aclk) begin : item_driver
        deque_op_t next_op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                next_op = op_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_op.kind;
                s_tdata  <= {{(S_TDATA_W - POS_W - DATA_IN_W){1'b0}}, next_op.pos, next_op.word};
                if (burst_left <= 1) begin
                    // Start a new burst; a quarter of them follow on with no gap at all
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a pattern that changes every 64 cycles, with two long hold-offs
    // during which the sender keeps offering items and the block must back up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            if ((rx_cycle >= HOLD_A_START && rx_cycle < HOLD_A_END) ||
                (rx_cycle >= HOLD_B_START && rx_cycle < HOLD_B_END)) begin
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_tready <= (rx_cycle % 8 < 5);
                endcase
            end
        end
    end

    // Monitor: predict on every accepted item first, then check any reply taken at this edge
    always @(posedge aclk) begin : reply_monitor
        deque_reply_t want;
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire) begin
            run_deque_op(s_tuser, s_tdata[DATA_IN_W-1:0], s_tdata[DATA_IN_W +: POS_W], want);
            deque_replies.push_back(want);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (deque_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none, got data %h status %0d count %0d",
                         $time, m_tdata[DATA_OUT_W-1:0], m_tuser, m_tdata[DATA_OUT_W +: COUNT_W]);
                mismatch_count++;
            end else begin
                want = deque_replies.pop_front();
                if (m_tdata[DATA_OUT_W-1:0] !== want.data) begin
                    $display("%0t: data_out mismatch, expected %h, got %h",
                             $time, want.data, m_tdata[DATA_OUT_W-1:0]);
                    mismatch_count++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[DATA_OUT_W +: COUNT_W] !== want.count) begin
                    $display("%0t: count mismatch, expected %0d, got %0d",
                             $time, want.count, m_tdata[DATA_OUT_W +: COUNT_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        // Directed: empty-deque errors, spare kinds, field extremes, wrap of the head pointer
        queue_op(KIND_POP_BACK,  32'h0, '0);
        queue_op(KIND_POP_FRONT, 32'hFFFF_FFFF, '1);
        queue_op(KIND_READ, 32'h0, '0);
        queue_op(KIND_READ, 32'hFFFF_FFFF, '1);
        queue_op(KIND_FIRST_SPARE, 32'h1234_5678, '1);
        queue_op(KIND_FIRST_SPARE + 3'd1, 32'hFFFF_FFFF, '0);
        queue_op(KIND_LAST_SPARE, 32'h0, 10'h2AA);
        queue_op(KIND_PUSH_FRONT, 32'hFFFF_FFFF, '1);
        queue_op(KIND_PUSH_BACK,  32'h0, '0);
        queue_op(KIND_PUSH_BACK,  32'hA5A5_5A5A, 10'h155);
        queue_op(KIND_PUSH_FRONT, 32'h8000_0001, '1);
        queue_op(KIND_READ, 32'hFFFF_FFFF, 10'd0);
        queue_op(KIND_READ, 32'h0, 10'd3);
        queue_op(KIND_READ, 32'h0, 10'd4);
        queue_op(KIND_READ, 32'h0, '1);
        queue_op(KIND_LAST_SPARE, 32'hDEAD_BEEF, 10'd1);
        queue_op(KIND_POP_FRONT, 32'h0, '0);
        queue_op(KIND_POP_BACK,  32'h0, '0);
        queue_op(KIND_POP_FRONT, 32'h0, '0);
        queue_op(KIND_POP_BACK,  32'h0, '0);
        queue_op(KIND_POP_FRONT, 32'h0, '0);
        queue_op(KIND_POP_BACK,  32'h0, '0);

        // Balanced mix around a small fill level
        repeat (150) queue_random_op(35, 35);
        // Fill to capacity, then knock on the full deque and read its far end
        while (gen_fill < CAPACITY) queue_random_op(90, 3);
        queue_op(KIND_PUSH_BACK,  $urandom, '1);
        queue_op(KIND_PUSH_FRONT, $urandom, '0);
        queue_op(KIND_READ, $urandom, POS_W'(CAPACITY - 1));
        queue_op(KIND_READ, $urandom, '0);
        repeat (20) queue_random_op(45, 10);
        // Drain to empty, then a short mixed tail
        while (gen_fill > 0) queue_random_op(3, 90);
        repeat (50) queue_random_op(35, 35);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for the backlog to go out and every reply to come back, then let the block settle
        while (op_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (deque_replies.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_deque.sv
verif/tb_circular_deque.sv
